FILE: src/fts_pkg.sv
`default_nettype none
package fts_pkg;

  localparam int unsigned FIX_SHIFT  = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [RECIP_W-1:0] INV_WIDTH_RST = 17'd82;

  // input commands
  typedef enum logic {
    CMD_ROW   = 1'b0,
    CMD_PIXEL = 1'b1
  } fts_cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_LEFT_RAY_X  = 3'd2,
    CFG_LEFT_RAY_Y  = 3'd3,
    CFG_RAY_SPAN_X  = 3'd4,
    CFG_RAY_SPAN_Y  = 3'd5,
    CFG_EYE_HEIGHT  = 3'd6,
    CFG_INV_WIDTH   = 3'd7
  } fts_cfg_t;

  // row setup sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_SPX,
    ST_STX,
    ST_SPY,
    ST_STY,
    ST_LX,
    ST_LY,
    ST_FIN
  } fts_state_t;

  // operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MOP_RD,
    MOP_SPAN_X,
    MOP_SCALE,
    MOP_SPAN_Y,
    MOP_LEFT_X,
    MOP_LEFT_Y
  } fts_mop_t;

  typedef struct packed {
    logic     busy;
    logic     div_start;
    logic     mul_en;
    fts_mop_t mul_op;
    logic     ld_rd;
    logic     ld_step_x;
    logic     ld_step_y;
    logic     ld_pos_x;
    logic     ld_pos_y;
  } fts_ctrl_t;

  typedef struct packed {
    logic [0:0]       command;
    logic [ROW_W-1:0] row_offset;
  } fts_in_t;

  typedef struct packed {
    logic [15:0] texel_index;
    logic [7:0]  tex_u;
    logic [7:0]  tex_v;
  } fts_out_t;

endpackage
`default_nettype wire

FILE: src/fts_div.sv
`default_nettype none
// Restoring divider: 65536 / divisor, one quotient bit per cycle.
module fts_div
  import fts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start_i,
  input  wire logic [ROW_W-1:0]   divisor_i,
  output logic                    done_o,
  output logic [RECIP_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(RECIP_W + 1);

  logic [RECIP_W-1:0] quo_r, quo_nxt;
  logic [ROW_W-1:0]   rem_r, rem_nxt;
  logic [ROW_W-1:0]   dvs_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [ROW_W:0]     trial;
  logic [ROW_W:0]     diff;
  logic               qbit;

  // one restoring step
  always_comb begin
    trial = {rem_r, quo_r[RECIP_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start_i) begin
      quo_nxt = RECIP_W'(1) << FIX_SHIFT;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(RECIP_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[RECIP_W-2:0], qbit};
      rem_nxt  = qbit ? diff[ROW_W-1:0] : trial[ROW_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath; zero divisor is taken as one
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start_i) begin
      dvs_r <= (divisor_i == '0) ? ROW_W'(1) : divisor_i;
    end
  end

  assign done_o = done_r;
  assign quot_o = quo_r;

endmodule
`default_nettype wire

FILE: src/fts_fmul.sv
`default_nettype none
// Shared 16.16 multiplier: (a * b) >>> 16, low 32 bits, registered.
module fts_fmul
  import fts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en_i,
  input  wire logic signed [WORD_W-1:0] a_i,
  input  wire logic signed [WORD_W:0]   b_i,
  output logic [WORD_W-1:0]             prod_o
);

  logic signed [2*WORD_W:0] prod;
  logic [WORD_W-1:0]        res_r;

  assign prod = a_i * b_i;

  always_ff @(posedge clk) begin
    if (en_i) begin
      res_r <= prod[FIX_SHIFT +: WORD_W];
    end
  end

  assign prod_o = res_r;

endmodule
`default_nettype wire

FILE: src/fts_ctrl.sv
`default_nettype none
// Row setup sequencer: divide, then seven multiplier slots and a final load.
module fts_ctrl
  import fts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   row_start_i,
  input  wire logic   div_done_i,
  output fts_ctrl_t   ctrl_o
);

  fts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (row_start_i) state_nxt = ST_DIV;
      ST_DIV:  if (div_done_i) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_SPX;
      ST_SPX:  state_nxt = ST_STX;
      ST_STX:  state_nxt = ST_SPY;
      ST_SPY:  state_nxt = ST_STY;
      ST_STY:  state_nxt = ST_LX;
      ST_LX:   state_nxt = ST_LY;
      ST_LY:   state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.busy      = (state_r != ST_IDLE);
    ctrl_o.div_start = (state_r == ST_IDLE) && row_start_i;
    ctrl_o.mul_op    = MOP_RD;
    unique case (state_r)
      ST_RD: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MOP_RD;
      end
      ST_SPX: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MOP_SPAN_X;
        ctrl_o.ld_rd  = 1'b1;
      end
      ST_STX: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MOP_SCALE;
      end
      ST_SPY: begin
        ctrl_o.mul_en    = 1'b1;
        ctrl_o.mul_op    = MOP_SPAN_Y;
        ctrl_o.ld_step_x = 1'b1;
      end
      ST_STY: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MOP_SCALE;
      end
      ST_LX: begin
        ctrl_o.mul_en    = 1'b1;
        ctrl_o.mul_op    = MOP_LEFT_X;
        ctrl_o.ld_step_y = 1'b1;
      end
      ST_LY: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_op   = MOP_LEFT_Y;
        ctrl_o.ld_pos_x = 1'b1;
      end
      ST_FIN: begin
        ctrl_o.ld_pos_y = 1'b1;
      end
      default: begin
        ctrl_o.mul_en = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/floor_texel_address_stepper.sv
`default_nettype none
// Pixel beat: one per cycle unless stalled; result is in the output register next cycle.
// Row start beat: busy through the bit-per-cycle divider, a handoff,
// seven slots of the shared multiplier and a final load; no result; input stalls meanwhile.
// A full output register that is stalled also stalls input.
// Synchronous active-low reset clears control, configuration (inverse_width to 82) and
// the floor position and step to zero.
module floor_texel_address_stepper
  import fts_pkg::*;
#(
  parameter int unsigned TEX_LOG2_WIDTH  = 8,
  parameter int unsigned TEX_LOG2_HEIGHT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fts_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fts_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = TEX_LOG2_WIDTH + TEX_LOG2_HEIGHT + 16;

  logic [WORD_W-1:0]  cam_x_r, cam_y_r, left_x_r, left_y_r;
  logic [WORD_W-1:0]  span_x_r, span_y_r, eye_r;
  logic [RECIP_W-1:0] inv_w_r;
  logic [WORD_W-1:0]  pos_x_r, pos_y_r, step_x_r, step_y_r, rd_r;
  logic               out_valid_r;
  fts_out_t           out_data_r;

  fts_ctrl_t            ctrl;
  logic                 accept, row_start, pixel_acc;
  logic                 div_done;
  logic [RECIP_W-1:0]   recip;
  logic [WORD_W-1:0]    mul_a;
  logic [WORD_W:0]      mul_b;
  logic [WORD_W-1:0]    mul_res;

  logic [TEX_LOG2_WIDTH-1:0]  u;
  logic [TEX_LOG2_HEIGHT-1:0] v;
  logic [IDX_W-1:0]           idx_wide;
  logic [TEX_LOG2_WIDTH+7:0]  u_wide;
  logic [TEX_LOG2_HEIGHT+7:0] v_wide;

  // handshake
  assign in_stall  = ctrl.busy || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign row_start = accept && (in_data.command == CMD_ROW);
  assign pixel_acc = accept && (in_data.command == CMD_PIXEL);

  fts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_start_i (row_start),
    .div_done_i  (div_done),
    .ctrl_o      (ctrl)
  );

  fts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (ctrl.div_start),
    .divisor_i (in_data.row_offset),
    .done_o    (div_done),
    .quot_o    (recip)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = rd_r;
    mul_b = {{(WORD_W+1-RECIP_W){1'b0}}, recip};
    unique case (ctrl.mul_op)
      MOP_RD: begin
        mul_a = eye_r;
        mul_b = {{(WORD_W+1-RECIP_W){1'b0}}, recip};
      end
      MOP_SPAN_X: begin
        mul_a = mul_res;
        mul_b = {span_x_r[WORD_W-1], span_x_r};
      end
      MOP_SCALE: begin
        mul_a = mul_res;
        mul_b = {{(WORD_W+1-RECIP_W){1'b0}}, inv_w_r};
      end
      MOP_SPAN_Y: begin
        mul_a = rd_r;
        mul_b = {span_y_r[WORD_W-1], span_y_r};
      end
      MOP_LEFT_X: begin
        mul_a = rd_r;
        mul_b = {left_x_r[WORD_W-1], left_x_r};
      end
      MOP_LEFT_Y: begin
        mul_a = rd_r;
        mul_b = {left_y_r[WORD_W-1], left_y_r};
      end
      default: begin
        mul_a = rd_r;
      end
    endcase
  end

  fts_fmul u_fmul (
    .clk    (clk),
    .en_i   (ctrl.mul_en),
    .a_i    ($signed(mul_a)),
    .b_i    ($signed(mul_b)),
    .prod_o (mul_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      left_x_r <= '0;
      left_y_r <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      eye_r    <= '0;
      inv_w_r  <= INV_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (fts_cfg_t'(cfg_index))
        CFG_CAMERA_X:   cam_x_r  <= cfg_data;
        CFG_CAMERA_Y:   cam_y_r  <= cfg_data;
        CFG_LEFT_RAY_X: left_x_r <= cfg_data;
        CFG_LEFT_RAY_Y: left_y_r <= cfg_data;
        CFG_RAY_SPAN_X: span_x_r <= cfg_data;
        CFG_RAY_SPAN_Y: span_y_r <= cfg_data;
        CFG_EYE_HEIGHT: eye_r    <= cfg_data;
        CFG_INV_WIDTH:  inv_w_r  <= cfg_data[RECIP_W-1:0];
        default:        inv_w_r  <= inv_w_r;
      endcase
    end
  end

  // row distance holding register
  always_ff @(posedge clk) begin
    if (ctrl.ld_rd) begin
      rd_r <= mul_res;
    end
  end

  // floor step and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= '0;
      step_y_r <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
    end else begin
      if (ctrl.ld_step_x) step_x_r <= mul_res;
      if (ctrl.ld_step_y) step_y_r <= mul_res;
      if (ctrl.ld_pos_x) begin
        pos_x_r <= cam_x_r + mul_res;
      end else if (pixel_acc) begin
        pos_x_r <= pos_x_r + step_x_r;
      end
      if (ctrl.ld_pos_y) begin
        pos_y_r <= cam_y_r + mul_res;
      end else if (pixel_acc) begin
        pos_y_r <= pos_y_r + step_y_r;
      end
    end
  end

  // texel address from the fractional floor position
  always_comb begin
    u        = pos_x_r[FIX_SHIFT-1 -: TEX_LOG2_WIDTH];
    v        = pos_y_r[FIX_SHIFT-1 -: TEX_LOG2_HEIGHT];
    idx_wide = {16'b0, v, u};
    u_wide   = {8'b0, u};
    v_wide   = {8'b0, v};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pixel_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      out_data_r.texel_index <= idx_wide[15:0];
      out_data_r.tex_u       <= u_wide[7:0];
      out_data_r.tex_v       <= v_wide[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: src/fts_checker.sv
`default_nettype none
// Port-level checks for the floor texel address stepper.
module fts_checker
  import fts_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire fts_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire fts_out_t out_data
);

  logic in_row, in_pix;
  assign in_row = in_valid && !in_stall && (in_data.command == CMD_ROW);
  assign in_pix = in_valid && !in_stall && (in_data.command == CMD_PIXEL);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // a row start keeps the input stalled at the start of row setup
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_row |=> in_stall ##1 in_stall)
    else $error("input taken during row setup");

  // every accepted pixel shows a result beat next cycle
  a_pix_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix |=> out_valid)
    else $error("pixel beat gave no result");

  // a new result only follows a pixel beat
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_pix))
    else $error("result beat without pixel");

endmodule

bind floor_texel_address_stepper fts_checker u_fts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
